// ===== design/tccc_pkg.sv =====
package tccc_pkg;

    // Field widths
    localparam int COORD_W    = 12;
    localparam int COLOR_W    = 24;
    localparam int CHAR_W     = 8;
    localparam int SEL_W      = 8;
    localparam int SCALE_W    = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int UPC_W      = 4;

    // Font cell base size in pixels
    localparam int CELL_BASE_DEF = 8;
    localparam int TAB_SPACES    = 4;

    // Character and stream codes
    localparam logic [CHAR_W-1:0] CHAR_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CHAR_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] CHAR_TAB       = 8'd9;
    localparam logic [CHAR_W-1:0] CHAR_SPACE     = 8'h20;
    localparam logic [SEL_W-1:0]  SEL_NORMAL     = 8'd1;
    localparam logic [SEL_W-1:0]  SEL_ERROR      = 8'd2;

    // Operation and command codes
    localparam logic OP_PRINT   = 1'b0;
    localparam logic OP_CLEAR   = 1'b1;
    localparam logic CMD_DRAW   = 1'b0;
    localparam logic CMD_SCROLL = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE         = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FOREGROUND    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BACKGROUND    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ERROR_COLOR   = 3'd5;

    // Configuration reset values
    localparam logic [COORD_W-1:0] RST_SCREEN_WIDTH  = 12'd1024;
    localparam logic [COORD_W-1:0] RST_SCREEN_HEIGHT = 12'd768;
    localparam logic [SCALE_W-1:0] RST_SCALE         = 4'd2;
    localparam logic [COLOR_W-1:0] RST_FOREGROUND    = 24'hFFFFFF;
    localparam logic [COLOR_W-1:0] RST_BACKGROUND    = 24'h000000;
    localparam logic [COLOR_W-1:0] RST_ERROR_COLOR   = 24'h3333FF;

    typedef struct packed {
        logic              operation;
        logic [CHAR_W-1:0] char_code;
        logic [SEL_W-1:0]  stream_select;
    } item_t;

    typedef struct packed {
        logic               command;
        logic [CHAR_W-1:0]  glyph_code;
        logic [COORD_W-1:0] pos_x;
        logic [COORD_W-1:0] pos_y;
        logic [COLOR_W-1:0] text_color;
        logic [COLOR_W-1:0] fill_color;
        logic [COORD_W-1:0] scroll_rows;
        logic               last;
    } result_t;

    typedef struct packed {
        logic [COORD_W-1:0] screen_width;
        logic [COORD_W-1:0] screen_height;
        logic [SCALE_W-1:0] scale;
        logic [COLOR_W-1:0] foreground_color;
        logic [COLOR_W-1:0] background_color;
        logic [COLOR_W-1:0] error_color;
    } cfg_t;

    // Microcode fields
    typedef enum logic [1:0] {
        EMIT_NONE,
        EMIT_GLYPH,
        EMIT_SCROLL_CELL,
        EMIT_SCROLL_ALL
    } emit_t;

    typedef enum logic {
        GLYPH_LATCHED,
        GLYPH_SPACE
    } glyph_sel_t;

    typedef enum logic {
        COLOR_STREAM,
        COLOR_FOREGROUND
    } color_sel_t;

    typedef enum logic [1:0] {
        LAST_NONE,
        LAST_ONE,
        LAST_GLYPH,
        LAST_CNT_ZERO
    } last_t;

    typedef enum logic [3:0] {
        ALU_NOP,
        ALU_HOME,
        ALU_LF,
        ALU_ADV,
        ALU_BS_X,
        ALU_DIV_INIT,
        ALU_DIV_STEP,
        ALU_BS_WRAP
    } alu_t;

    typedef enum logic [2:0] {
        COND_ALWAYS,
        COND_DISPATCH,
        COND_SCROLL,
        COND_WRAP_SCROLL,
        COND_X_ZERO,
        COND_Y_ZERO,
        COND_CNT_MORE,
        COND_DIV_MORE
    } cond_t;

    typedef logic [UPC_W-1:0] upc_t;

    // Microprogram addresses
    localparam upc_t UPC_IDLE         = 4'd0;
    localparam upc_t UPC_CLEAR        = 4'd1;
    localparam upc_t UPC_NL           = 4'd2;
    localparam upc_t UPC_NL_SCROLL    = 4'd3;
    localparam upc_t UPC_NL_MOVE      = 4'd4;
    localparam upc_t UPC_GLYPH        = 4'd5;
    localparam upc_t UPC_GLYPH_SCROLL = 4'd6;
    localparam upc_t UPC_GLYPH_NEXT   = 4'd7;
    localparam upc_t UPC_BS           = 4'd8;
    localparam upc_t UPC_BS_UP        = 4'd9;
    localparam upc_t UPC_BS_LEFT      = 4'd10;
    localparam upc_t UPC_BS_DRAW      = 4'd11;
    localparam upc_t UPC_DIV_INIT     = 4'd12;
    localparam upc_t UPC_DIV_STEP     = 4'd13;
    localparam upc_t UPC_BS_WRAP      = 4'd14;

    typedef struct packed {
        emit_t      emit;
        glyph_sel_t glyph_sel;
        color_sel_t color_sel;
        last_t      last;
        alu_t       alu;
        cond_t      cond;
        upc_t       addr_t;
        upc_t       addr_f;
    } ucode_t;

    typedef struct packed {
        logic   fire;
        logic   load;
        ucode_t uc;
    } ctrl_t;

    typedef struct packed {
        logic scroll;
        logic wrap_scroll;
        logic x_zero;
        logic y_zero;
        logic cnt_zero;
        logic cnt_one;
        logic emit_ok;
    } flags_t;

    // Control store: one word per step, jump to addr_t when cond holds, else addr_f (dispatch picks the entry)
    function automatic ucode_t ucode_rom(input upc_t addr);
        ucode_t w;
        w = '{EMIT_NONE, GLYPH_LATCHED, COLOR_STREAM, LAST_NONE, ALU_NOP,
              COND_ALWAYS, UPC_IDLE, UPC_IDLE};
        unique case (addr)
            UPC_IDLE:
                w = '{EMIT_NONE, GLYPH_LATCHED, COLOR_STREAM, LAST_NONE, ALU_NOP,
                      COND_DISPATCH, UPC_IDLE, UPC_IDLE};
            UPC_CLEAR:
                w = '{EMIT_SCROLL_ALL, GLYPH_LATCHED, COLOR_STREAM, LAST_ONE, ALU_HOME,
                      COND_ALWAYS, UPC_IDLE, UPC_IDLE};
            UPC_NL:
                w = '{EMIT_NONE, GLYPH_LATCHED, COLOR_STREAM, LAST_NONE, ALU_NOP,
                      COND_SCROLL, UPC_NL_SCROLL, UPC_NL_MOVE};
            UPC_NL_SCROLL:
                w = '{EMIT_SCROLL_CELL, GLYPH_LATCHED, COLOR_STREAM, LAST_ONE, ALU_LF,
                      COND_ALWAYS, UPC_IDLE, UPC_IDLE};
            UPC_NL_MOVE:
                w = '{EMIT_NONE, GLYPH_LATCHED, COLOR_STREAM, LAST_NONE, ALU_LF,
                      COND_ALWAYS, UPC_IDLE, UPC_IDLE};
            UPC_GLYPH:
                w = '{EMIT_GLYPH, GLYPH_LATCHED, COLOR_STREAM, LAST_GLYPH, ALU_ADV,
                      COND_WRAP_SCROLL, UPC_GLYPH_SCROLL, UPC_GLYPH_NEXT};
            UPC_GLYPH_SCROLL:
                w = '{EMIT_SCROLL_CELL, GLYPH_LATCHED, COLOR_STREAM, LAST_CNT_ZERO,
                      ALU_NOP, COND_CNT_MORE, UPC_GLYPH, UPC_IDLE};
            UPC_GLYPH_NEXT:
                w = '{EMIT_NONE, GLYPH_LATCHED, COLOR_STREAM, LAST_NONE, ALU_NOP,
                      COND_CNT_MORE, UPC_GLYPH, UPC_IDLE};
            UPC_BS:
                w = '{EMIT_NONE, GLYPH_LATCHED, COLOR_STREAM, LAST_NONE, ALU_NOP,
                      COND_X_ZERO, UPC_BS_UP, UPC_BS_LEFT};
            UPC_BS_UP:
                w = '{EMIT_NONE, GLYPH_LATCHED, COLOR_STREAM, LAST_NONE, ALU_NOP,
                      COND_Y_ZERO, UPC_BS_DRAW, UPC_DIV_INIT};
            UPC_BS_LEFT:
                w = '{EMIT_NONE, GLYPH_LATCHED, COLOR_STREAM, LAST_NONE, ALU_BS_X,
                      COND_ALWAYS, UPC_BS_DRAW, UPC_BS_DRAW};
            UPC_BS_DRAW:
                w = '{EMIT_GLYPH, GLYPH_SPACE, COLOR_FOREGROUND, LAST_ONE, ALU_NOP,
                      COND_ALWAYS, UPC_IDLE, UPC_IDLE};
            UPC_DIV_INIT:
                w = '{EMIT_NONE, GLYPH_LATCHED, COLOR_STREAM, LAST_NONE, ALU_DIV_INIT,
                      COND_ALWAYS, UPC_DIV_STEP, UPC_DIV_STEP};
            UPC_DIV_STEP:
                w = '{EMIT_NONE, GLYPH_LATCHED, COLOR_STREAM, LAST_NONE, ALU_DIV_STEP,
                      COND_DIV_MORE, UPC_DIV_STEP, UPC_BS_WRAP};
            UPC_BS_WRAP:
                w = '{EMIT_NONE, GLYPH_LATCHED, COLOR_STREAM, LAST_NONE, ALU_BS_WRAP,
                      COND_ALWAYS, UPC_BS_DRAW, UPC_BS_DRAW};
            default:
                w = '{EMIT_NONE, GLYPH_LATCHED, COLOR_STREAM, LAST_NONE, ALU_NOP,
                      COND_ALWAYS, UPC_IDLE, UPC_IDLE};
        endcase
        return w;
    endfunction

    // Entry point of the microprogram for an accepted item
    function automatic upc_t dispatch_entry(input item_t it);
        upc_t a;
        a = UPC_GLYPH;
        if (it.operation == OP_CLEAR)
            a = UPC_CLEAR;
        else if (it.stream_select != SEL_NORMAL && it.stream_select != SEL_ERROR)
            a = UPC_IDLE;
        else if (it.char_code == CHAR_NEWLINE)
            a = UPC_NL;
        else if (it.char_code == CHAR_BACKSPACE)
            a = UPC_BS;
        return a;
    endfunction

endpackage

// ===== design/tccc_sequencer.sv =====
module tccc_sequencer (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  tccc_pkg::item_t  item,
    input  tccc_pkg::flags_t flags,
    output tccc_pkg::ctrl_t  ctrl
);
    import tccc_pkg::*;

    upc_t   upc_reg;
    upc_t   upc_next;
    ucode_t uc;
    logic   load;
    logic   fire;
    logic   cond_true;

    // Fetch the control word of the current step
    assign uc = ucode_rom(upc_reg);

    // Take a new item only at the dispatch step
    assign item_stall = (uc.cond != COND_DISPATCH);
    assign load       = item_valid && !item_stall;

    // Hold a step that emits until the output register can take it
    always_comb
    begin
        if (uc.cond == COND_DISPATCH)
            fire = load;
        else
            fire = (uc.emit == EMIT_NONE) || flags.emit_ok;
    end

    // Evaluate the jump condition
    always_comb
    begin
        unique case (uc.cond)
            COND_ALWAYS:      cond_true = 1'b1;
            COND_DISPATCH:    cond_true = 1'b1;
            COND_SCROLL:      cond_true = flags.scroll;
            COND_WRAP_SCROLL: cond_true = flags.wrap_scroll;
            COND_X_ZERO:      cond_true = flags.x_zero;
            COND_Y_ZERO:      cond_true = flags.y_zero;
            COND_CNT_MORE:    cond_true = !flags.cnt_zero;
            COND_DIV_MORE:    cond_true = !flags.cnt_one;
        endcase
    end

    // Select the next step
    always_comb
    begin
        upc_next = upc_reg;
        if (fire)
        begin
            if (uc.cond == COND_DISPATCH)
                upc_next = dispatch_entry(item);
            else if (cond_true)
                upc_next = uc.addr_t;
            else
                upc_next = uc.addr_f;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            upc_reg <= UPC_IDLE;
        else
            upc_reg <= upc_next;
    end

    assign ctrl.fire = fire;
    assign ctrl.load = load;
    assign ctrl.uc   = uc;

endmodule

// ===== design/tccc_datapath.sv =====
module tccc_datapath #(
    parameter int CELL_BASE = tccc_pkg::CELL_BASE_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  tccc_pkg::cfg_t    cfg,
    input  tccc_pkg::item_t   item,
    input  tccc_pkg::ctrl_t   ctrl,
    output tccc_pkg::flags_t  flags,
    output logic              result_valid,
    input  logic              result_stall,
    output tccc_pkg::result_t result
);
    import tccc_pkg::*;

    localparam int CellMax = (2 ** SCALE_W - 1) * CELL_BASE;
    localparam int CellW   = $clog2(CellMax + 1);
    localparam int SumW    = $clog2((2 ** COORD_W - 1) + 2 * CellMax + 1);
    localparam int LoopW   = $clog2(COORD_W + 1);

    localparam logic [CellW-1:0] CellBaseC = CellW'(CELL_BASE);
    localparam logic [LoopW-1:0] DivSteps  = LoopW'(COORD_W);
    localparam logic [LoopW-1:0] TabCount  = LoopW'(TAB_SPACES);
    localparam logic [LoopW-1:0] LoopOne   = LoopW'(1);

    logic [COORD_W-1:0] cursor_x_reg, cursor_x_next;
    logic [COORD_W-1:0] cursor_y_reg, cursor_y_next;
    logic [CellW-1:0]   cell_reg, cell_next;
    logic [LoopW-1:0]   loop_reg, loop_next;
    logic [CHAR_W-1:0]  glyph_reg, glyph_next;
    logic               err_reg, err_next;
    logic [CellW-1:0]   rem_reg, rem_next;
    logic [COORD_W-1:0] dvd_reg, dvd_next;
    logic               out_valid_reg, out_valid_next;
    result_t            out_reg, out_next;

    logic [SCALE_W-1:0] scale_eff;
    logic [CellW-1:0]   cell_load;
    logic [COORD_W-1:0] cell_c;
    logic [SumW-1:0]    two_cell;
    logic               scroll;
    logic               wrap;
    logic [COORD_W-1:0] x_adv;
    logic [COORD_W-1:0] y_adv;
    logic [COORD_W-1:0] x_back;
    logic [COORD_W-1:0] y_back;
    logic [CellW:0]     trial;
    logic [CellW-1:0]   rem_step;
    logic [COORD_W-1:0] span;
    logic [COORD_W-1:0] col_last;
    logic               emit_ok;
    logic               last_bit;
    logic [COLOR_W-1:0] stream_color;

    // Cell size; a zero scale counts as one
    assign scale_eff = (cfg.scale == '0) ? SCALE_W'(1) : cfg.scale;
    assign cell_load = CellW'(scale_eff) * CellBaseC;
    assign cell_c    = COORD_W'(cell_reg);
    assign two_cell  = SumW'(cell_reg) << 1;

    // Line overflow and right margin tests
    assign scroll = (SumW'(cursor_y_reg) + two_cell) >= SumW'(cfg.screen_height);
    assign wrap   = (SumW'(cursor_x_reg) + two_cell) > SumW'(cfg.screen_width);

    // Cursor steps, saturating on the way back
    assign x_adv  = cursor_x_reg + cell_c;
    assign y_adv  = cursor_y_reg + cell_c;
    assign x_back = (cursor_x_reg >= cell_c) ? cursor_x_reg - cell_c : '0;
    assign y_back = (cursor_y_reg >= cell_c) ? cursor_y_reg - cell_c : '0;

    // Restoring divider step for screen_width mod cell
    assign trial    = {rem_reg, dvd_reg[COORD_W-1]};
    assign rem_step = (trial >= {1'b0, cell_reg}) ? CellW'(trial - {1'b0, cell_reg})
                                                  : trial[CellW-1:0];

    // Left edge of the last whole column
    assign span     = cfg.screen_width - COORD_W'(rem_reg);
    assign col_last = (span >= cell_c) ? span - cell_c : '0;

    assign emit_ok = !out_valid_reg || !result_stall;

    assign flags.scroll      = scroll;
    assign flags.wrap_scroll = wrap && scroll;
    assign flags.x_zero      = (cursor_x_reg == '0);
    assign flags.y_zero      = (cursor_y_reg == '0);
    assign flags.cnt_zero    = (loop_reg == '0);
    assign flags.cnt_one     = (loop_reg == LoopOne);
    assign flags.emit_ok     = emit_ok;

    // Latch the item and run the selected datapath operation
    always_comb
    begin
        cursor_x_next = cursor_x_reg;
        cursor_y_next = cursor_y_reg;
        cell_next     = cell_reg;
        loop_next     = loop_reg;
        glyph_next    = glyph_reg;
        err_next      = err_reg;
        rem_next      = rem_reg;
        dvd_next      = dvd_reg;
        if (ctrl.load)
        begin
            cell_next  = cell_load;
            err_next   = (item.stream_select == SEL_ERROR);
            if (item.char_code == CHAR_TAB)
            begin
                loop_next  = TabCount;
                glyph_next = CHAR_SPACE;
            end
            else
            begin
                loop_next  = LoopOne;
                glyph_next = item.char_code;
            end
        end
        if (ctrl.fire)
        begin
            unique case (ctrl.uc.alu)
                ALU_NOP:
                begin
                end
                ALU_HOME:
                begin
                    cursor_x_next = '0;
                    cursor_y_next = '0;
                end
                ALU_LF:
                begin
                    cursor_x_next = '0;
                    if (!scroll)
                        cursor_y_next = y_adv;
                end
                ALU_ADV:
                begin
                    loop_next = loop_reg - LoopOne;
                    if (wrap)
                    begin
                        cursor_x_next = '0;
                        if (!scroll)
                            cursor_y_next = y_adv;
                    end
                    else
                        cursor_x_next = x_adv;
                end
                ALU_BS_X:
                    cursor_x_next = x_back;
                ALU_DIV_INIT:
                begin
                    rem_next  = '0;
                    dvd_next  = cfg.screen_width;
                    loop_next = DivSteps;
                end
                ALU_DIV_STEP:
                begin
                    rem_next  = rem_step;
                    dvd_next  = {dvd_reg[COORD_W-2:0], 1'b0};
                    loop_next = loop_reg - LoopOne;
                end
                ALU_BS_WRAP:
                begin
                    cursor_y_next = y_back;
                    cursor_x_next = col_last;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Last flag of the emitted command
    always_comb
    begin
        unique case (ctrl.uc.last)
            LAST_NONE:     last_bit = 1'b0;
            LAST_ONE:      last_bit = 1'b1;
            LAST_GLYPH:    last_bit = (loop_reg == LoopOne) && !(wrap && scroll);
            LAST_CNT_ZERO: last_bit = (loop_reg == '0);
        endcase
    end

    assign stream_color = err_reg ? cfg.error_color : cfg.foreground_color;

    // Load the output register on an emitting step, drop it once taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (out_valid_reg && !result_stall)
            out_valid_next = 1'b0;
        if (ctrl.fire && ctrl.uc.emit != EMIT_NONE)
        begin
            out_valid_next       = 1'b1;
            out_next.command     = CMD_SCROLL;
            out_next.glyph_code  = '0;
            out_next.pos_x       = '0;
            out_next.pos_y       = '0;
            out_next.text_color  = '0;
            out_next.fill_color  = cfg.background_color;
            out_next.scroll_rows = '0;
            out_next.last        = last_bit;
            unique case (ctrl.uc.emit)
                EMIT_NONE:
                begin
                end
                EMIT_GLYPH:
                begin
                    out_next.command    = CMD_DRAW;
                    out_next.glyph_code = (ctrl.uc.glyph_sel == GLYPH_SPACE) ? CHAR_SPACE
                                                                             : glyph_reg;
                    out_next.pos_x      = cursor_x_reg;
                    out_next.pos_y      = cursor_y_reg;
                    out_next.text_color = (ctrl.uc.color_sel == COLOR_FOREGROUND)
                                          ? cfg.foreground_color : stream_color;
                end
                EMIT_SCROLL_CELL:
                    out_next.scroll_rows = cell_c;
                EMIT_SCROLL_ALL:
                    out_next.scroll_rows = cfg.screen_height;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_x_reg  <= '0;
            cursor_y_reg  <= '0;
            loop_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cursor_x_reg  <= cursor_x_next;
            cursor_y_reg  <= cursor_y_next;
            loop_reg      <= loop_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cell_reg  <= cell_next;
        glyph_reg <= glyph_next;
        err_reg   <= err_next;
        rem_reg   <= rem_next;
        dvd_reg   <= dvd_next;
        out_reg   <= out_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

// ===== design/text_console_cursor_controller.sv =====
// Cursor and scroll controller for a scaled text console. Each item either
// prints one character on stream 1 (normal color) or stream 2 (error color),
// or clears the screen; the block answers with draw-glyph and scroll-up
// commands for a pixel engine, the final one of each item marked by last.
// The cell is max(scale,1) * CELL_BASE pixels square. Newline, backspace
// and tab (four spaces) are handled here; items on other streams are
// swallowed with no command. A microcoded sequencer runs one item at a time;
// a backspace that wraps to the previous row runs a bit-serial divider that
// finds the last whole column. An emitting step waits while the single output
// register is full and the output side stalls. Configuration must be written
// only between items by the user; the block does not enforce this.
module text_console_cursor_controller #(
    parameter int CELL_BASE = tccc_pkg::CELL_BASE_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [tccc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tccc_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            item_valid,
    output logic                            item_stall,
    input  tccc_pkg::item_t                 item,
    output logic                            result_valid,
    input  logic                            result_stall,
    output tccc_pkg::result_t               result
);
    import tccc_pkg::*;

    cfg_t   cfg_reg, cfg_next;
    ctrl_t  ctrl;
    flags_t flags;

    // Write one configuration register
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_SCREEN_WIDTH:  cfg_next.screen_width     = cfg_data[COORD_W-1:0];
                REG_SCREEN_HEIGHT: cfg_next.screen_height    = cfg_data[COORD_W-1:0];
                REG_SCALE:         cfg_next.scale            = cfg_data[SCALE_W-1:0];
                REG_FOREGROUND:    cfg_next.foreground_color = cfg_data[COLOR_W-1:0];
                REG_BACKGROUND:    cfg_next.background_color = cfg_data[COLOR_W-1:0];
                REG_ERROR_COLOR:   cfg_next.error_color      = cfg_data[COLOR_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.screen_width     <= RST_SCREEN_WIDTH;
            cfg_reg.screen_height    <= RST_SCREEN_HEIGHT;
            cfg_reg.scale            <= RST_SCALE;
            cfg_reg.foreground_color <= RST_FOREGROUND;
            cfg_reg.background_color <= RST_BACKGROUND;
            cfg_reg.error_color      <= RST_ERROR_COLOR;
        end
        else
            cfg_reg <= cfg_next;
    end

    tccc_sequencer u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .flags      (flags),
        .ctrl       (ctrl)
    );

    tccc_datapath #(
        .CELL_BASE (CELL_BASE)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .item         (item),
        .ctrl         (ctrl),
        .flags        (flags),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    // An emitting step never overwrites a result that is still waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.fire && ctrl.uc.emit != EMIT_NONE) |-> flags.emit_ok)
        else $error("command emitted while output register blocked");

    // A clear transaction goes straight to the full-screen scroll
    assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.load && item.operation == OP_CLEAR) |=> (ctrl.uc.emit == EMIT_SCROLL_ALL))
        else $error("clear did not start with full-screen scroll");

    // Scroll commands carry no glyph, position or text color
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.command == CMD_SCROLL) |->
            (result.glyph_code == '0 && result.pos_x == '0 && result.pos_y == '0
             && result.text_color == '0))
        else $error("scroll command with glyph fields set");

    // Glyph commands carry no scroll count
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.command == CMD_DRAW) |-> (result.scroll_rows == '0))
        else $error("draw command with scroll rows set");

endmodule

// ===== sim/text_console_cursor_controller_tb.sv =====
`timescale 1ns / 1ps

module text_console_cursor_controller_tb;
    import tccc_pkg::*;

    localparam int CELL_PX     = CELL_BASE_DEF;
    localparam int SETTLE_CYC  = 30;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 14;
    localparam int N_ROWS      = 36;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;
    // How a directed row gets its expected commands
    typedef enum logic [1:0] {EXP_MODEL, EXP_NONE, EXP_ONE} exp_mode_t;

    typedef struct {
        row_kind_t                kind;
        item_t                    it;
        logic [CFG_IDX_W-1:0]     reg_idx;
        logic [CFG_DATA_W-1:0]    reg_data;
        exp_mode_t                mode;
        result_t                  want;
    } stim_row_t;

    localparam result_t NO_CMD = '0;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  item_valid = 1'b0;
    logic                  item_stall;
    item_t                 item = '0;
    logic                  result_valid;
    logic                  result_stall = 1'b0;
    result_t               result;

    // Console state and register copies kept by the predictor
    logic [COORD_W-1:0] scr_w, scr_h, cur_x, cur_y;
    logic [SCALE_W-1:0] scale_r;
    logic [COLOR_W-1:0] fg_color, bg_color, err_color;

    result_t step_cmds[$];
    result_t cmds_due[$];
    int      bad_cnt = 0;
    int      idle_pct = 0;
    int      stall_pct = 0;
    bit      busy = 1'b0;

    int idle_tab[4]  = '{0, 62, 0, 37};
    int stall_tab[4] = '{0, 0, 62, 37};

    stim_row_t dir_tab [0:N_ROWS-1] = '{
        '{ROW_ITEM, '{OP_CLEAR, 8'hFF, 8'hFF}, REG_SCREEN_WIDTH, 24'h0, EXP_ONE,
          '{CMD_SCROLL, 8'h00, 12'd0, 12'd0, 24'h000000, 24'h000000, 12'd768, 1'b1}},
        '{ROW_ITEM, '{OP_PRINT, 8'h41, SEL_NORMAL}, REG_SCREEN_WIDTH, 24'h0, EXP_ONE,
          '{CMD_DRAW, 8'h41, 12'd0, 12'd0, 24'hFFFFFF, 24'h000000, 12'd0, 1'b1}},
        '{ROW_ITEM, '{OP_PRINT, CHAR_BACKSPACE, SEL_ERROR}, REG_SCREEN_WIDTH, 24'h0, EXP_ONE,
          '{CMD_DRAW, CHAR_SPACE, 12'd0, 12'd0, 24'hFFFFFF, 24'h000000, 12'd0, 1'b1}},
        '{ROW_ITEM, '{OP_PRINT, CHAR_BACKSPACE, SEL_NORMAL}, REG_SCREEN_WIDTH, 24'h0, EXP_ONE,
          '{CMD_DRAW, CHAR_SPACE, 12'd0, 12'd0, 24'hFFFFFF, 24'h000000, 12'd0, 1'b1}},
        '{ROW_ITEM, '{OP_PRINT, 8'hFF, SEL_ERROR}, REG_SCREEN_WIDTH, 24'h0, EXP_ONE,
          '{CMD_DRAW, 8'hFF, 12'd0, 12'd0, 24'h3333FF, 24'h000000, 12'd0, 1'b1}},
        '{ROW_ITEM, '{OP_PRINT, 8'h00, SEL_NORMAL}, REG_SCREEN_WIDTH, 24'h0, EXP_ONE,
          '{CMD_DRAW, 8'h00, 12'd16, 12'd0, 24'hFFFFFF, 24'h000000, 12'd0, 1'b1}},
        '{ROW_ITEM, '{OP_PRINT, 8'h41, 8'h00}, REG_SCREEN_WIDTH, 24'h0, EXP_NONE, NO_CMD},
        '{ROW_ITEM, '{OP_PRINT, 8'h41, 8'hFF}, REG_SCREEN_WIDTH, 24'h0, EXP_NONE, NO_CMD},
        '{ROW_ITEM, '{OP_PRINT, 8'hFE, 8'h03}, REG_SCREEN_WIDTH, 24'h0, EXP_NONE, NO_CMD},
        '{ROW_ITEM, '{OP_PRINT, CHAR_NEWLINE, SEL_NORMAL}, REG_SCREEN_WIDTH, 24'h0,
          EXP_NONE, NO_CMD},
        '{ROW_ITEM, '{OP_PRINT, CHAR_TAB, SEL_ERROR}, REG_SCREEN_WIDTH, 24'h0,
          EXP_MODEL, NO_CMD},
        '{ROW_ITEM, '{OP_PRINT, CHAR_BACKSPACE, SEL_NORMAL}, REG_SCREEN_WIDTH, 24'h0,
          EXP_MODEL, NO_CMD},
        '{ROW_ITEM, '{OP_PRINT, CHAR_NEWLINE, SEL_ERROR}, REG_SCREEN_WIDTH, 24'h0,
          EXP_MODEL, NO_CMD},
        '{ROW_ITEM, '{OP_PRINT, CHAR_BACKSPACE, SEL_ERROR}, REG_SCREEN_WIDTH, 24'h0,
          EXP_MODEL, NO_CMD},
        '{ROW_ITEM, '{OP_PRINT, 8'h7A, SEL_NORMAL}, REG_SCREEN_WIDTH, 24'h0,
          EXP_MODEL, NO_CMD},
        '{ROW_CFG, '0, REG_FOREGROUND, 24'h000000, EXP_MODEL, NO_CMD},
        '{ROW_CFG, '0, REG_BACKGROUND, 24'hFFFFFF, EXP_MODEL, NO_CMD},
        '{ROW_CFG, '0, REG_ERROR_COLOR, 24'h000000, EXP_MODEL, NO_CMD},
        '{ROW_ITEM, '{OP_PRINT, 8'h7E, SEL_NORMAL}, REG_SCREEN_WIDTH, 24'h0, EXP_ONE,
          '{CMD_DRAW, 8'h7E, 12'd0, 12'd32, 24'h000000, 24'hFFFFFF, 12'd0, 1'b1}},
        '{ROW_CFG, '0, REG_SCALE, 24'd15, EXP_MODEL, NO_CMD},
        '{ROW_CFG, '0, REG_SCREEN_WIDTH, 24'd16, EXP_MODEL, NO_CMD},
        '{ROW_CFG, '0, REG_SCREEN_HEIGHT, 24'd16, EXP_MODEL, NO_CMD},
        '{ROW_ITEM, '{OP_PRINT, 8'h42, SEL_ERROR}, REG_SCREEN_WIDTH, 24'h0,
          EXP_MODEL, NO_CMD},
        '{ROW_ITEM, '{OP_PRINT, CHAR_BACKSPACE, SEL_NORMAL}, REG_SCREEN_WIDTH, 24'h0,
          EXP_MODEL, NO_CMD},
        '{ROW_CFG, '0, REG_SCALE, 24'd1, EXP_MODEL, NO_CMD},
        '{ROW_ITEM, '{OP_PRINT, 8'h71, SEL_NORMAL}, REG_SCREEN_WIDTH, 24'h0,
          EXP_MODEL, NO_CMD},
        // Step back from a column left over from a smaller cell
        '{ROW_CFG, '0, REG_SCALE, 24'd4, EXP_MODEL, NO_CMD},
        '{ROW_ITEM, '{OP_PRINT, CHAR_BACKSPACE, SEL_NORMAL}, REG_SCREEN_WIDTH, 24'h0,
          EXP_MODEL, NO_CMD},
        // Zero scale behaves as one
        '{ROW_CFG, '0, REG_SCALE, 24'd0, EXP_MODEL, NO_CMD},
        '{ROW_CFG, '0, REG_SCREEN_WIDTH, 24'd4095, EXP_MODEL, NO_CMD},
        '{ROW_CFG, '0, REG_SCREEN_HEIGHT, 24'd4095, EXP_MODEL, NO_CMD},
        '{ROW_ITEM, '{OP_PRINT, CHAR_TAB, SEL_NORMAL}, REG_SCREEN_WIDTH, 24'h0,
          EXP_MODEL, NO_CMD},
        '{ROW_ITEM, '{OP_PRINT, CHAR_NEWLINE, SEL_NORMAL}, REG_SCREEN_WIDTH, 24'h0,
          EXP_MODEL, NO_CMD},
        '{ROW_ITEM, '{OP_CLEAR, CHAR_NEWLINE, SEL_NORMAL}, REG_SCREEN_WIDTH, 24'h0, EXP_ONE,
          '{CMD_SCROLL, 8'h00, 12'd0, 12'd0, 24'h000000, 24'hFFFFFF, 12'd4095, 1'b1}},
        '{ROW_CFG, '0, REG_SCREEN_HEIGHT, 24'd16, EXP_MODEL, NO_CMD},
        '{ROW_ITEM, '{OP_PRINT, CHAR_NEWLINE, SEL_ERROR}, REG_SCREEN_WIDTH, 24'h0,
          EXP_MODEL, NO_CMD}
    };

    text_console_cursor_controller #(
        .CELL_BASE(CELL_PX)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .item_valid(item_valid),
        .item_stall(item_stall),
        .item(item),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result(result)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Hard stop if the run hangs
    initial
    begin
        #(5_000_000);
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic int unsigned cell_px();
        int unsigned s;
        s = (scale_r == '0) ? 1 : scale_r;
        return s * CELL_PX;
    endfunction

    task automatic note_fail(input string msg);
        bad_cnt++;
        if (bad_cnt <= 10)
            $display("%s", msg);
    endtask

    task automatic emit_cmd(input logic cmd, input logic [CHAR_W-1:0] g,
                            input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                            input logic [COLOR_W-1:0] tc, input logic [COORD_W-1:0] rows);
        result_t r;
        r.command     = cmd;
        r.glyph_code  = g;
        r.pos_x       = x;
        r.pos_y       = y;
        r.text_color  = tc;
        r.fill_color  = bg_color;
        r.scroll_rows = rows;
        r.last        = 1'b0;
        step_cmds.push_back(r);
    endtask

    // Line feed: scroll one cell when the next row would not fit
    task automatic console_newline();
        int unsigned c;
        c = cell_px();
        cur_x = '0;
        if (cur_y + 2 * c >= scr_h)
            emit_cmd(CMD_SCROLL, 8'h00, 12'd0, 12'd0, 24'd0, 12'(c));
        else
            cur_y = 12'(cur_y + c);
    endtask

    task automatic console_glyph(input logic [CHAR_W-1:0] g, input logic [COLOR_W-1:0] tc);
        int unsigned c, nx;
        c = cell_px();
        emit_cmd(CMD_DRAW, g, cur_x, cur_y, tc, 12'd0);
        nx = cur_x + c;
        if (nx + c > scr_w)
            console_newline();
        else
            cur_x = 12'(nx);
    endtask

    // Step back one cell, wrapping to the last whole column of the row above
    task automatic console_backspace();
        int unsigned c, span;
        c = cell_px();
        if (cur_x == '0)
        begin
            if (cur_y != '0)
            begin
                span = (scr_w / c) * c;
                cur_y = (cur_y >= c) ? 12'(cur_y - c) : 12'd0;
                cur_x = (span >= c) ? 12'(span - c) : 12'd0;
            end
        end
        else
        begin
            cur_x = (cur_x >= c) ? 12'(cur_x - c) : 12'd0;
        end
        emit_cmd(CMD_DRAW, CHAR_SPACE, cur_x, cur_y, fg_color, 12'd0);
    endtask

    // Work out the commands one transaction causes
    task automatic console_step(input item_t it);
        logic [COLOR_W-1:0] tc;
        step_cmds.delete();
        if (it.operation == OP_CLEAR)
        begin
            cur_x = '0;
            emit_cmd(CMD_SCROLL, 8'h00, 12'd0, 12'd0, 24'd0, scr_h);
            cur_y = '0;
        end
        else if (it.stream_select == SEL_NORMAL || it.stream_select == SEL_ERROR)
        begin
            tc = (it.stream_select == SEL_ERROR) ? err_color : fg_color;
            if (it.char_code == CHAR_NEWLINE)
                console_newline();
            else if (it.char_code == CHAR_BACKSPACE)
                console_backspace();
            else if (it.char_code == CHAR_TAB)
                repeat (TAB_SPACES) console_glyph(CHAR_SPACE, tc);
            else
                console_glyph(it.char_code, tc);
        end
        if (step_cmds.size() > 0)
            step_cmds[step_cmds.size()-1].last = 1'b1;
    endtask

    task automatic console_config(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_SCREEN_WIDTH:  scr_w = data[COORD_W-1:0];
            REG_SCREEN_HEIGHT: scr_h = data[COORD_W-1:0];
            REG_SCALE:         scale_r = data[SCALE_W-1:0];
            REG_FOREGROUND:    fg_color = data[COLOR_W-1:0];
            REG_BACKGROUND:    bg_color = data[COLOR_W-1:0];
            REG_ERROR_COLOR:   err_color = data[COLOR_W-1:0];
            default: ;
        endcase
    endtask

    // Drive one input transaction, with an optional gap in front of it
    task automatic send_item(input item_t it);
        if ($urandom_range(0, 99) < idle_pct)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        item_valid <= 1'b1;
        item <= it;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
    endtask

    // Send, predict, and queue what the transaction should produce
    task automatic push_item(input item_t it, input exp_mode_t mode, input result_t want);
        send_item(it);
        console_step(it);
        if (mode != EXP_MODEL)
        begin
            step_cmds.delete();
            if (mode == EXP_ONE)
                step_cmds.push_back(want);
        end
        foreach (step_cmds[k])
            cmds_due.push_back(step_cmds[k]);
        busy = 1'b1;
    endtask

    // Drop valid, drain all commands, then let any silent transaction finish
    task automatic settle();
        item_valid <= 1'b0;
        while (cmds_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
        busy = 1'b0;
    endtask

    task automatic cfg_put(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        if (busy)
            settle();
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        console_config(idx, data);
        @(posedge clk);
    endtask

    function automatic logic [COORD_W-1:0] pick_dim();
        case ($urandom_range(0, 3))
            0:       return 12'd16;
            1:       return 12'd4095;
            2:       return 12'($urandom_range(16, 200));
            default: return 12'($urandom_range(16, 4095));
        endcase
    endfunction

    function automatic logic [SCALE_W-1:0] pick_scale();
        case ($urandom_range(0, 7))
            0:       return 4'd0;
            1:       return 4'd15;
            default: return 4'($urandom_range(1, 4));
        endcase
    endfunction

    // Mostly character traffic on the two streams, some clears and noise
    function automatic item_t rand_item();
        item_t it;
        int    r, v;
        r = $urandom_range(0, 99);
        it.operation = OP_PRINT;
        it.char_code = 8'($urandom_range(0, 255));
        it.stream_select = (r % 2 == 0) ? SEL_NORMAL : SEL_ERROR;
        if (r < 3)
        begin
            it.operation = OP_CLEAR;
            it.stream_select = 8'($urandom_range(0, 255));
        end
        else if (r < 13)
        begin
            v = $urandom_range(2, 255);
            it.stream_select = (v == 2) ? 8'd0 : 8'(v);
        end
        else
        begin
            v = $urandom_range(0, 99);
            if (v < 12)
                it.char_code = CHAR_NEWLINE;
            else if (v < 22)
                it.char_code = CHAR_BACKSPACE;
            else if (v < 30)
                it.char_code = CHAR_TAB;
        end
        return it;
    endfunction

    function automatic string field_diff(input result_t a, input result_t b);
        string s;
        s = "";
        if (a.command !== b.command)         s = {s, " command"};
        if (a.glyph_code !== b.glyph_code)   s = {s, " glyph_code"};
        if (a.pos_x !== b.pos_x)             s = {s, " pos_x"};
        if (a.pos_y !== b.pos_y)             s = {s, " pos_y"};
        if (a.text_color !== b.text_color)   s = {s, " text_color"};
        if (a.fill_color !== b.fill_color)   s = {s, " fill_color"};
        if (a.scroll_rows !== b.scroll_rows) s = {s, " scroll_rows"};
        if (a.last !== b.last)               s = {s, " last"};
        return s;
    endfunction

    // Stall the command side at random
    always @(posedge clk)
        result_stall <= ($urandom_range(0, 99) < stall_pct);

    // Check each command transaction against the oldest expectation
    always @(posedge clk)
    begin : cmd_check
        result_t want;
        string   diff;
        if (rst_n && result_valid && !result_stall)
        begin
            if (cmds_due.size() == 0)
            begin
                note_fail($sformatf("unexpected command %h", result));
            end
            else
            begin
                want = cmds_due.pop_front();
                diff = field_diff(want, result);
                if (diff != "")
                    note_fail($sformatf("command mismatch:%s expected %h got %h",
                                        diff, want, result));
            end
        end
    end

    initial
    begin : stimulus
        item_t it;
        int    ph, counted;
        scr_w     = RST_SCREEN_WIDTH;
        scr_h     = RST_SCREEN_HEIGHT;
        scale_r   = RST_SCALE;
        fg_color  = RST_FOREGROUND;
        bg_color  = RST_BACKGROUND;
        err_color = RST_ERROR_COLOR;
        cur_x     = '0;
        cur_y     = '0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed rows
        foreach (dir_tab[i])
        begin
            if (dir_tab[i].kind == ROW_CFG)
                cfg_put(dir_tab[i].reg_idx, dir_tab[i].reg_data);
            else
                push_item(dir_tab[i].it, dir_tab[i].mode, dir_tab[i].want);
        end

        // Random phases, each with fresh settings and an idling and stall mix from the tables
        for (ph = 0; ph < PHASES; ph++)
        begin
            cfg_put(REG_SCREEN_WIDTH, {12'($urandom), pick_dim()});
            cfg_put(REG_SCREEN_HEIGHT, {12'($urandom), pick_dim()});
            cfg_put(REG_SCALE, {20'($urandom), pick_scale()});
            cfg_put(REG_FOREGROUND, 24'($urandom));
            cfg_put(REG_BACKGROUND, 24'($urandom));
            cfg_put(REG_ERROR_COLOR, 24'($urandom));
            idle_pct = idle_tab[ph % 4];
            stall_pct = stall_tab[ph % 4];
            counted = 0;
            while (counted < PHASE_ITEMS)
            begin
                it = rand_item();
                push_item(it, EXP_MODEL, NO_CMD);
                if (it.operation == OP_CLEAR || it.stream_select == SEL_NORMAL ||
                    it.stream_select == SEL_ERROR)
                    counted++;
            end
        end

        settle();
        if (bad_cnt == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
design/tccc_pkg.sv
design/tccc_sequencer.sv
design/tccc_datapath.sv
design/text_console_cursor_controller.sv
sim/text_console_cursor_controller_tb.sv
